// ===== design/pmt_pkg.sv =====
package pmt_pkg;

    localparam int MOVE_MAX_CHARS = 8;
    localparam int NEST_MAX       = 255;

    localparam int CHAR_W = 8;
    localparam int NUM_W  = 16;
    localparam int TEXT_W = 64;
    localparam int LEN_W  = 4;
    localparam int GAME_W = 2;
    localparam int NEST_W = 8;
    localparam int OUT_DATA_W = 88;

    localparam logic [NUM_W-1:0] NUM_NONE = 16'hFFFF;
    localparam logic [NUM_W-1:0] NUM_SAT  = 16'h7FFF;

    localparam logic [CHAR_W-1:0] C_STAR   = 8'h2A;
    localparam logic [CHAR_W-1:0] C_DOLLAR = 8'h24;
    localparam logic [CHAR_W-1:0] C_LPAR   = 8'h28;
    localparam logic [CHAR_W-1:0] C_RPAR   = 8'h29;
    localparam logic [CHAR_W-1:0] C_LBRACE = 8'h7B;
    localparam logic [CHAR_W-1:0] C_RBRACE = 8'h7D;
    localparam logic [CHAR_W-1:0] C_SEMI   = 8'h3B;
    localparam logic [CHAR_W-1:0] C_PCT    = 8'h25;
    localparam logic [CHAR_W-1:0] C_DOT    = 8'h2E;
    localparam logic [CHAR_W-1:0] C_SLASH  = 8'h2F;
    localparam logic [CHAR_W-1:0] C_DASH   = 8'h2D;
    localparam logic [CHAR_W-1:0] C_EQ     = 8'h3D;
    localparam logic [CHAR_W-1:0] C_PLUS   = 8'h2B;
    localparam logic [CHAR_W-1:0] C_HASH   = 8'h23;
    localparam logic [CHAR_W-1:0] C_LF     = 8'h0A;
    localparam logic [CHAR_W-1:0] C_ZERO   = 8'h30;

    localparam logic KIND_MOVE   = 1'b0;
    localparam logic KIND_RESULT = 1'b1;

    localparam logic REQ_BYTE     = 1'b0;
    localparam logic REQ_NEW_GAME = 1'b1;

    localparam logic [GAME_W-1:0] GAME_WHITE = 2'd0;
    localparam logic [GAME_W-1:0] GAME_BLACK = 2'd1;
    localparam logic [GAME_W-1:0] GAME_DRAW  = 2'd2;
    localparam logic [GAME_W-1:0] GAME_STAR  = 2'd3;

    typedef struct packed {
        logic       is_nul;
        logic       is_digit;
        logic       is_space;
        logic       is_move;
        logic [3:0] digit;
    } t_char_class;

endpackage

// ===== design/pmt_char_class.sv =====
module pmt_char_class (
    input  logic [pmt_pkg::CHAR_W-1:0] i_char,
    output pmt_pkg::t_char_class       o_class
);

    logic w_digit;
    logic w_alpha;

    always_comb begin
        w_digit = (i_char >= 8'h30) && (i_char <= 8'h39);
        w_alpha = ((i_char >= 8'h61) && (i_char <= 8'h7A)) ||
                  ((i_char >= 8'h41) && (i_char <= 8'h5A));
        o_class.is_nul   = (i_char == 8'h00);
        o_class.is_digit = w_digit;
        o_class.is_space = (i_char == 8'h20) || ((i_char >= 8'h09) && (i_char <= 8'h0D));
        o_class.is_move  = w_alpha || w_digit || (i_char == pmt_pkg::C_DASH) ||
                           (i_char == pmt_pkg::C_EQ) || (i_char == pmt_pkg::C_PLUS) ||
                           (i_char == pmt_pkg::C_HASH);
        o_class.digit    = 4'(i_char - pmt_pkg::C_ZERO);
    end

endmodule

// ===== design/pgn_movetext_tokenizer.sv =====
// Chess game movetext tokenizer.
// Slave channel: one request per byte. tdata carries the movetext byte,
// tuser = 1 restarts for a new game (the byte is then ignored).
// Master channel: one request per completed move or game result.
// tuser is the kind (0 move, 1 result); tdata packs move number, move
// text, move length and game result. Bytes that only advance the parse
// (separators, comments, variations, NAGs) give no output request.
// Throughput is one byte per cycle while the receiver takes results: the
// parser is a single pass of short logic (classifier, multiply by ten, state
// update) between the input register and the output register.
// The byte parses from the input register into the output register.
// When the receiver stalls the output register holds the pending result;
// the input register takes one more byte, then o_s_tready falls until the
// pending result is taken.
// Reset (synchronous, active low) empties both registers and returns the
// parser to move start with no move number pending.
module pgn_movetext_tokenizer (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    input  logic [pmt_pkg::CHAR_W-1:0]       i_s_tdata,  // [7:0] char_in
    input  logic                             i_s_tuser,  // [0] req_type
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // [15:0] move_number, [79:16] move_text, [83:80] move_length,
    // [85:84] game_result, [87:86] zero
    output logic [pmt_pkg::OUT_DATA_W-1:0]   o_m_tdata,
    output logic                             o_m_tuser   // [0] out_kind
);

    typedef enum logic [3:0] {
        S_START = 4'd0,
        S_MOVE  = 4'd1,
        S_NUM   = 4'd2,
        S_NAG   = 4'd3,
        S_BRACE = 4'd4,
        S_LINE  = 4'd5,
        S_VAR   = 4'd6,
        S_ESC   = 4'd7,
        S_OVER  = 4'd8
    } t_state;

    logic                          r_in_valid;
    logic                          r_in_req;
    logic [pmt_pkg::CHAR_W-1:0]    r_in_char;

    t_state                        r_state, n_state;
    logic [pmt_pkg::NUM_W-1:0]     r_num, n_num;
    logic [pmt_pkg::TEXT_W-1:0]    r_chars, n_chars;
    logic [pmt_pkg::LEN_W-1:0]     r_count, n_count;
    logic [pmt_pkg::NEST_W-1:0]    r_nest, n_nest;

    logic                          r_out_valid;
    logic                          r_out_kind;
    logic [pmt_pkg::NUM_W-1:0]     r_out_num;
    logic [pmt_pkg::TEXT_W-1:0]    r_out_text;
    logic [pmt_pkg::LEN_W-1:0]     r_out_len;
    logic [pmt_pkg::GAME_W-1:0]    r_out_game;

    logic                          w_fire;
    logic                          w_res_valid;
    logic                          w_res_kind;
    logic [pmt_pkg::NUM_W-1:0]     w_res_num;
    logic [pmt_pkg::TEXT_W-1:0]    w_res_text;
    logic [pmt_pkg::LEN_W-1:0]     w_res_len;
    logic [pmt_pkg::GAME_W-1:0]    w_res_game;
    logic [18:0]                   w_num_x10;
    logic [pmt_pkg::TEXT_W-1:0]    w_added_chars;
    logic [pmt_pkg::LEN_W-1:0]     w_added_count;
    logic [pmt_pkg::NEST_W-1:0]    w_nest_dec;
    pmt_pkg::t_char_class          w_cc;

    pmt_char_class u_class (
        .i_char  (r_in_char),
        .o_class (w_cc)
    );

    assign w_fire     = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || w_fire;

    // accumulator is non-negative while a number is being read
    assign w_num_x10 = {1'b0, r_num[14:0], 3'b000} + {3'b000, r_num[14:0], 1'b0}
                     + {15'd0, w_cc.digit};

    assign w_nest_dec = (r_nest != '0) ? r_nest - 8'd1 : r_nest;

    always_comb begin
        w_added_chars = r_chars;
        w_added_count = r_count;
        if (r_count < pmt_pkg::LEN_W'(pmt_pkg::MOVE_MAX_CHARS)) begin
            for (int i = 0; i < pmt_pkg::MOVE_MAX_CHARS; i++) begin
                if (r_count == pmt_pkg::LEN_W'(i)) begin
                    w_added_chars[8*i +: 8] = r_in_char;
                end
            end
            w_added_count = r_count + 4'd1;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_num       = r_num;
        n_chars     = r_chars;
        n_count     = r_count;
        n_nest      = r_nest;
        w_res_valid = 1'b0;
        w_res_kind  = pmt_pkg::KIND_MOVE;
        w_res_num   = '0;
        w_res_text  = '0;
        w_res_len   = '0;
        w_res_game  = pmt_pkg::GAME_WHITE;
        if (r_in_req == pmt_pkg::REQ_NEW_GAME) begin
            n_state = S_START;
            n_num   = pmt_pkg::NUM_NONE;
            n_chars = '0;
            n_count = '0;
            n_nest  = '0;
        end else if (!w_cc.is_nul) begin
            unique case (r_state)
                S_START: begin
                    if (w_cc.is_digit) begin
                        n_state = S_NUM;
                        n_num   = {12'd0, w_cc.digit};
                    end else if (w_cc.is_move) begin
                        n_state = S_MOVE;
                        n_chars = {56'd0, r_in_char};
                        n_count = 4'd1;
                    end else if (r_in_char == pmt_pkg::C_STAR) begin
                        n_state     = S_OVER;
                        w_res_valid = 1'b1;
                        w_res_kind  = pmt_pkg::KIND_RESULT;
                        w_res_game  = pmt_pkg::GAME_STAR;
                    end else if (r_in_char == pmt_pkg::C_DOLLAR) begin
                        n_state = S_NAG;
                    end else if (r_in_char == pmt_pkg::C_LPAR) begin
                        n_state = S_VAR;
                        n_nest  = 8'd1;
                    end else if (r_in_char == pmt_pkg::C_LBRACE) begin
                        n_state = S_BRACE;
                    end else if (r_in_char == pmt_pkg::C_SEMI) begin
                        n_state = S_LINE;
                    end else if (r_in_char == pmt_pkg::C_PCT) begin
                        n_state = S_ESC;
                    end
                end
                S_NUM: begin
                    if (w_cc.is_digit) begin
                        n_num = (w_num_x10 > 19'(pmt_pkg::NUM_SAT)) ? pmt_pkg::NUM_SAT
                                                                   : w_num_x10[15:0];
                    end else if (r_in_char == pmt_pkg::C_DOT || w_cc.is_space) begin
                        n_state = S_START;
                    end else if (r_in_char == pmt_pkg::C_SLASH) begin
                        n_state     = S_OVER;
                        w_res_valid = 1'b1;
                        w_res_kind  = pmt_pkg::KIND_RESULT;
                        w_res_game  = pmt_pkg::GAME_DRAW;
                    end else if (r_in_char == pmt_pkg::C_DASH) begin
                        n_state     = S_OVER;
                        w_res_valid = 1'b1;
                        w_res_kind  = pmt_pkg::KIND_RESULT;
                        w_res_game  = (r_num == 16'd1) ? pmt_pkg::GAME_WHITE
                                                       : pmt_pkg::GAME_BLACK;
                    end
                end
                S_MOVE: begin
                    if (w_cc.is_move) begin
                        n_chars = w_added_chars;
                        n_count = w_added_count;
                    end else begin
                        w_res_valid = 1'b1;
                        w_res_kind  = pmt_pkg::KIND_MOVE;
                        w_res_num   = r_num;
                        w_res_text  = r_chars;
                        w_res_len   = r_count;
                        n_state     = S_START;
                        n_num       = pmt_pkg::NUM_NONE;
                        n_chars     = '0;
                        n_count     = '0;
                        n_nest      = '0;
                    end
                end
                S_NAG: begin
                    if (!w_cc.is_digit) begin
                        n_state = S_START;
                    end
                end
                S_BRACE: begin
                    if (r_in_char == pmt_pkg::C_RBRACE) begin
                        n_state = S_START;
                    end
                end
                S_LINE, S_ESC: begin
                    if (r_in_char == pmt_pkg::C_LF) begin
                        n_state = S_START;
                    end
                end
                S_VAR: begin
                    if (r_in_char == pmt_pkg::C_RPAR) begin
                        n_nest = w_nest_dec;
                        if (w_nest_dec == '0) begin
                            n_state = S_START;
                        end
                    end else if (r_in_char == pmt_pkg::C_LPAR) begin
                        if (r_nest < pmt_pkg::NEST_W'(pmt_pkg::NEST_MAX)) begin
                            n_nest = r_nest + 8'd1;
                        end
                    end
                end
                S_OVER: begin
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= S_START;
            r_num       <= pmt_pkg::NUM_NONE;
            r_chars     <= '0;
            r_count     <= '0;
            r_nest      <= '0;
        end else begin
            if (o_s_tready) begin
                r_in_valid <= i_s_tvalid;
            end
            if (i_s_tvalid && o_s_tready) begin
                r_in_req  <= i_s_tuser;
                r_in_char <= i_s_tdata;
            end
            if (w_fire) begin
                r_state     <= n_state;
                r_num       <= n_num;
                r_chars     <= n_chars;
                r_count     <= n_count;
                r_nest      <= n_nest;
                r_out_valid <= w_res_valid;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            if (w_fire && w_res_valid) begin
                r_out_kind <= w_res_kind;
                r_out_num  <= w_res_num;
                r_out_text <= w_res_text;
                r_out_len  <= w_res_len;
                r_out_game <= w_res_game;
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_kind;
    assign o_m_tdata  = {2'b00, r_out_game, r_out_len, r_out_text, r_out_num};

endmodule

// ===== sim/tb_pgn_movetext_tokenizer.sv =====
`timescale 1ns / 1ps

module tb_pgn_movetext_tokenizer;
    import pmt_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 300;
    localparam int RANDOM_ITEMS = 150;
    localparam int STEADY_ITEMS = 90;

    typedef enum logic [3:0] {
        PS_START, PS_MOVE, PS_NUM, PS_NAG, PS_BRACE, PS_LINE, PS_VAR, PS_ESC, PS_OVER
    } t_parse;

    typedef struct packed {
        logic                kind;
        logic [NUM_W-1:0]    number;
        logic [TEXT_W-1:0]   text;
        logic [LEN_W-1:0]    len;
        logic [GAME_W-1:0]   game;
    } t_token;

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_s_tvalid = 1'b0;
    logic                  o_s_tready;
    logic [CHAR_W-1:0]     i_s_tdata  = '0;   // [7:0] char_in
    logic                  i_s_tuser  = 1'b0; // [0] req_type
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    // [15:0] move_number, [79:16] move_text, [83:80] move_length, [85:84] game_result
    logic [OUT_DATA_W-1:0] o_m_tdata;
    logic                  o_m_tuser;         // [0] out_kind

    t_token  expected_tokens[$];
    t_parse  p_state;
    int      p_num;
    logic [TEXT_W-1:0] p_text;
    int      p_len;
    int      p_depth;

    int      mismatches   = 0;
    int      items_sent   = 0;
    int      cycle_count  = 0;
    bit      idle_on      = 1'b1;
    bit      hold_request = 1'b0;

    pgn_movetext_tokenizer i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // ---- tokenizer predictor ----

    function automatic logic is_digit(input logic [7:0] c);
        return c >= C_ZERO && c <= C_ZERO + 8'd9;
    endfunction

    function automatic logic is_move_char(input logic [7:0] c);
        return is_digit(c) || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
               c == C_DASH || c == C_EQ || c == C_PLUS || c == C_HASH;
    endfunction

    task automatic clear_parser();
        p_state = PS_START;
        p_num   = -1;
        p_text  = '0;
        p_len   = 0;
        p_depth = 0;
    endtask

    task automatic append_move_char(input logic [7:0] c);
        if (p_len < MOVE_MAX_CHARS) begin
            p_text[8*p_len +: 8] = c;
            p_len++;
        end
    endtask

    task automatic post_game_result(input logic [GAME_W-1:0] code);
        t_token tok;
        tok      = '0;
        tok.kind = KIND_RESULT;
        tok.game = code;
        expected_tokens.push_back(tok);
        p_state = PS_OVER;
    endtask

    task automatic predict_request(input logic req, input logic [7:0] c);
        t_token tok;
        int v;
        if (req == REQ_NEW_GAME) begin
            clear_parser();
            return;
        end
        if (c == 8'h00)
            return;
        case (p_state)
            PS_START: begin
                if (is_digit(c)) begin
                    p_state = PS_NUM;
                    p_num   = int'(c) - int'(C_ZERO);
                end else if (is_move_char(c)) begin
                    p_state = PS_MOVE;
                    p_text  = '0;
                    p_len   = 0;
                    append_move_char(c);
                end else if (c == C_STAR) begin
                    post_game_result(GAME_STAR);
                end else if (c == C_DOLLAR) begin
                    p_state = PS_NAG;
                end else if (c == C_LPAR) begin
                    p_depth = 1;
                    p_state = PS_VAR;
                end else if (c == C_LBRACE) begin
                    p_state = PS_BRACE;
                end else if (c == C_SEMI) begin
                    p_state = PS_LINE;
                end else if (c == C_PCT) begin
                    p_state = PS_ESC;
                end
            end
            PS_NUM: begin
                if (is_digit(c)) begin
                    v     = p_num * 10 + (int'(c) - int'(C_ZERO));
                    p_num = (v > int'(NUM_SAT)) ? int'(NUM_SAT) : v;
                end else if (c == C_DOT || c == " " || (c >= 8'h09 && c <= 8'h0D)) begin
                    p_state = PS_START;
                end else if (c == C_SLASH) begin
                    post_game_result(GAME_DRAW);
                end else if (c == C_DASH) begin
                    post_game_result((p_num == 1) ? GAME_WHITE : GAME_BLACK);
                end
            end
            PS_MOVE: begin
                if (is_move_char(c)) begin
                    append_move_char(c);
                end else begin
                    tok        = '0;
                    tok.kind   = KIND_MOVE;
                    tok.number = 16'(p_num);
                    tok.text   = p_text;
                    tok.len    = LEN_W'(p_len);
                    expected_tokens.push_back(tok);
                    clear_parser();
                end
            end
            PS_NAG: begin
                if (!is_digit(c))
                    p_state = PS_START;
            end
            PS_BRACE: begin
                if (c == C_RBRACE)
                    p_state = PS_START;
            end
            PS_LINE, PS_ESC: begin
                if (c == C_LF)
                    p_state = PS_START;
            end
            PS_VAR: begin
                if (c == C_RPAR) begin
                    if (p_depth > 0)
                        p_depth--;
                    if (p_depth == 0)
                        p_state = PS_START;
                end else if (c == C_LPAR) begin
                    if (p_depth < NEST_MAX)
                        p_depth++;
                end
            end
            default: ;
        endcase
    endtask

    // ---- sender ----

    task automatic send_request(input logic req, input logic [7:0] byte_val);
        if (idle_on && $urandom_range(0, 7) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= byte_val;
        i_s_tuser  <= req;
        do @(posedge i_clk); while (!o_s_tready);
        items_sent++;
        predict_request(req, byte_val);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_request(REQ_BYTE, s[i]);
    endtask

    function automatic logic [7:0] pick_char(input string s);
        return s[$urandom_range(0, s.len() - 1)];
    endfunction

    function automatic logic [7:0] byte_other_than(input logic [7:0] c);
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255)); while (b == c);
        return b;
    endfunction

    task automatic send_random_token();
        int pick;
        int n;
        int depth;
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 11) : $urandom_range(1, 6);
            send_request(REQ_BYTE, pick_char("abcdefghNBRQKOP-"));
            for (int i = 1; i < n; i++) begin
                if ($urandom_range(0, 15) == 0)
                    send_request(REQ_BYTE, 8'h00);
                send_request(REQ_BYTE, pick_char("abcdefgh12345678xNBRQKO-=+#"));
            end
            if ($urandom_range(0, 5) == 0)
                send_request(REQ_BYTE, 8'($urandom_range(128, 255)));
            else
                send_request(REQ_BYTE, pick_char(" \n\t)!?("));
        end else if (pick < 48) begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(10000, 999999)
                                            : $urandom_range(0, 120);
            send_text($sformatf("%0d", n));
            case ($urandom_range(0, 2))
                0: send_text(".");
                1: send_text("...");
                default: send_text(" ");
            endcase
        end else if (pick < 54) begin
            send_text($sformatf("$%0d", $urandom_range(0, 255)));
            send_request(REQ_BYTE, 8'($urandom_range(0, 255)));
        end else if (pick < 60) begin
            send_request(REQ_BYTE, C_LBRACE);
            repeat ($urandom_range(0, 8)) send_request(REQ_BYTE, byte_other_than(C_RBRACE));
            send_request(REQ_BYTE, C_RBRACE);
        end else if (pick < 66) begin
            send_request(REQ_BYTE, ($urandom_range(0, 1) == 0) ? C_SEMI : C_PCT);
            repeat ($urandom_range(0, 8)) send_request(REQ_BYTE, byte_other_than(C_LF));
            send_request(REQ_BYTE, C_LF);
        end else if (pick < 73) begin
            depth = 1;
            send_request(REQ_BYTE, C_LPAR);
            repeat ($urandom_range(1, 12)) begin
                case ($urandom_range(0, 5))
                    0: if (depth < 4) begin
                        depth++;
                        send_request(REQ_BYTE, C_LPAR);
                    end
                    1: if (depth > 1) begin
                        depth--;
                        send_request(REQ_BYTE, C_RPAR);
                    end
                    default: send_request(REQ_BYTE, pick_char("e4Nf3 .1{}*"));
                endcase
            end
            repeat (depth) send_request(REQ_BYTE, C_RPAR);
        end else if (pick < 86) begin
            send_request(REQ_BYTE, pick_char(" \n\t\r"));
        end else if (pick < 94) begin
            send_request(REQ_BYTE, 8'($urandom_range(0, 255)));
        end else if (pick < 98) begin
            case ($urandom_range(0, 4))
                0: send_text("1-0");
                1: send_text("0-1");
                2: send_text("1/2-1/2");
                3: send_text("*");
                default: send_text($sformatf("%0d-", $urandom_range(2, 40)));
            endcase
            repeat ($urandom_range(0, 4)) send_request(REQ_BYTE, 8'($urandom_range(0, 255)));
            send_request(REQ_NEW_GAME, 8'($urandom_range(0, 255)));
        end else begin
            send_request(REQ_NEW_GAME, 8'($urandom_range(0, 255)));
        end
    endtask

    // ---- tests ----

    // saturated number, zero byte, truncated move ended by a high byte, result lockout
    task automatic test_directed();
        send_text("99999.");
        send_request(REQ_BYTE, 8'h00);
        send_text("Nf3xe5=Q+");
        send_request(REQ_BYTE, 8'hFF);
        send_text("1-0");
        send_text("e4 ");
        send_request(REQ_NEW_GAME, 8'hFF);
    endtask

    task automatic test_game_endings();
        send_text("2/");
        send_request(REQ_NEW_GAME, 8'h00);
        send_text("0-1");
        send_request(REQ_NEW_GAME, C_STAR);
        send_text("*");
        send_request(REQ_NEW_GAME, 8'h55);
        send_text("-e4)");
        send_request(REQ_NEW_GAME, 8'hAA);
    endtask

    task automatic test_deep_nesting();
        repeat (NEST_MAX + 2) send_request(REQ_BYTE, C_LPAR);
        send_text("e4 ");
        repeat (NEST_MAX) send_request(REQ_BYTE, C_RPAR);
        send_text("12...e4 ");
    endtask

    task automatic test_backpressure();
        hold_request = 1'b1;
        send_text("1.e4 e5 2.Nf3 Nc6 3.Bb5 a6 4.Ba4 Nf6 5.O-O Be7 ");
        send_request(REQ_NEW_GAME, 8'h00);
    endtask

    task automatic test_random_games();
        int start;
        start = items_sent;
        while (items_sent - start < RANDOM_ITEMS)
            send_random_token();
    endtask

    task automatic test_steady_stream();
        int start;
        idle_on = 1'b0;
        start   = items_sent;
        while (items_sent - start < STEADY_ITEMS)
            send_random_token();
    endtask

    initial begin
        clear_parser();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_game_endings();
        test_deep_nesting();
        test_backpressure();
        test_random_games();
        test_steady_stream();
        i_s_tvalid <= 1'b0;
        while (expected_tokens.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (mismatches == 0 && expected_tokens.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // ---- receiver ----

    initial begin : sink_ready
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left  = 0;
        wait (i_rst_n);
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_m_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                i_m_tready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 13) - 1;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    task automatic check_field(input string field, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t: %s expected %h actual %h", $time, field, want, got);
        end
    endtask

    initial begin : token_monitor
        t_token want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_m_tvalid && i_m_tready) begin
                if (expected_tokens.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected request expected none actual kind %0d data %h",
                             $time, o_m_tuser, o_m_tdata);
                end else begin
                    want = expected_tokens.pop_front();
                    check_field("out_kind", 64'(want.kind), 64'(o_m_tuser));
                    check_field("move_number", 64'(want.number), 64'(o_m_tdata[15:0]));
                    check_field("move_text", want.text, o_m_tdata[79:16]);
                    check_field("move_length", 64'(want.len), 64'(o_m_tdata[83:80]));
                    check_field("game_result", 64'(want.game), 64'(o_m_tdata[85:84]));
                end
            end
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("TEST FAILED");
        $finish;
    end

endmodule
